@@ sv/cubic_curve_point_eval_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cubic curve point evaluator
// Shared property shapes, clocked on clock and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CUBIC_CURVE_POINT_EVAL_MACROS_SVH
`define CUBIC_CURVE_POINT_EVAL_MACROS_SVH

// same-cycle implication
`define CCPE_ASSERT_IMPLY(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("ccpe: same-cycle check failed");

// next-cycle implication
`define CCPE_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("ccpe: next-cycle check failed");

`endif

@@ sv/ccpe_pkg.sv @@
// ---------------------------------------------------------------------------
// ccpe_pkg
// Types, widths and constants shared by the cubic curve point evaluator.
// ---------------------------------------------------------------------------
package ccpe_pkg;

   // base sizes
   localparam int COORD_BITS  = 16;
   localparam int T_FRAC_BITS = 16;
   localparam int PARAM_T_W   = T_FRAC_BITS + 1;
   localparam int COLOR_W     = 24;
   localparam int DIM_W       = 13;

   // weight datapath: t^2, t^3, and weights up to 7*S^3 before final value
   localparam int SQ_W     = 2 * T_FRAC_BITS + 1;
   localparam int CUBE_W   = 3 * T_FRAC_BITS + 1;
   localparam int WEIGHT_W = 3 * T_FRAC_BITS + 3;
   localparam int WSUM_W   = WEIGHT_W + 2;

   // weights are split in two halves for the coordinate multiplies
   localparam int LO_W        = (WEIGHT_W + 1) / 2;
   localparam int HI_W        = WEIGHT_W - LO_W;
   localparam int PROD_W      = LO_W + COORD_BITS + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int FLOOR_SHIFT = 3 * T_FRAC_BITS - LO_W;
   localparam int PX_W        = COORD_BITS + 3;

   // floor divide by six: bias to non-negative, multiply by reciprocal
   localparam int DIV_N_W = COORD_BITS + 3;
   localparam int DIV_K   = DIV_N_W + 3;
   localparam int RECIP_W = DIV_K - 2;
   localparam int DIV_P_W = DIV_N_W + RECIP_W;
   localparam longint unsigned DIV6_RECIP_VAL = ((64'd1 << DIV_K) + 64'd5) / 64'd6;
   localparam logic [RECIP_W-1:0] DIV6_RECIP  = RECIP_W'(DIV6_RECIP_VAL);
   localparam logic [DIV_N_W-1:0] DIV6_OFFSET = DIV_N_W'(6 * (1 << (COORD_BITS - 1)));
   localparam logic [COORD_BITS:0] HALF_RANGE = (COORD_BITS + 1)'(1) << (COORD_BITS - 1);

   localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

   // fixed-point one and the two weight totals
   localparam logic [PARAM_T_W-1:0] T_ONE   = PARAM_T_W'(1) << T_FRAC_BITS;
   localparam logic [WEIGHT_W-1:0]  S_CUBE  = WEIGHT_W'(1) << (3 * T_FRAC_BITS);
   localparam logic [WSUM_W-1:0] BEZIER_SUM  = WSUM_W'(1) << (3 * T_FRAC_BITS);
   localparam logic [WSUM_W-1:0] BSPLINE_SUM = (BEZIER_SUM << 2) + (BEZIER_SUM << 1);

   // register stages from accept to result
   localparam int W_STAGES   = 4;
   localparam int C_STAGES   = 3;
   localparam int PIPE_DEPTH = 9;

   // basis codes
   localparam logic BASIS_BEZIER  = 1'b0;
   localparam logic BASIS_BSPLINE = 1'b1;

   // CSR map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                 basis;
      logic [PARAM_T_W-1:0] param_t;
      coord_type            ctrl0_x;
      coord_type            ctrl0_y;
      coord_type            ctrl1_x;
      coord_type            ctrl1_y;
      coord_type            ctrl2_x;
      coord_type            ctrl2_y;
      coord_type            ctrl3_x;
      coord_type            ctrl3_y;
      logic [COLOR_W-1:0]   pixel_color;
   } req_type;

   typedef struct packed {
      coord_type          point_x;
      coord_type          point_y;
      logic               inside_res;
      logic [COLOR_W-1:0] paint_color;
   } rsp_type;

   // side data that rides along the weight, product and sum stages
   typedef struct packed {
      logic                 valid;
      logic                 basis;
      coord_type [3:0]      ctrl_x;
      coord_type [3:0]      ctrl_y;
      logic [COLOR_W-1:0]   color;
   } tag_type;

   typedef logic [3:0][WEIGHT_W-1:0] weight_type;

   // unscaled point, floored by S^3 only
   typedef struct packed {
      logic                   valid;
      logic                   basis;
      logic [COLOR_W-1:0]     color;
      logic signed [PX_W-1:0] x;
      logic signed [PX_W-1:0] y;
   } pos_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } bounds_type;

endpackage

@@ sv/ccpe_csr.sv @@
// ---------------------------------------------------------------------------
// ccpe_csr
// APB register file holding the image width and height.
// ---------------------------------------------------------------------------
module ccpe_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ccpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ccpe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ccpe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output ccpe_pkg::bounds_type          bounds
);
   import ccpe_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             wr_en;
   csr_reg_type      reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = csr_reg_type'(paddr[2]);

   // write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_IMAGE_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT: prdata = {{(CSR_DATA_W-DIM_W){1'b0}}, height_ff};
         default:          prdata = '0;
      endcase
   end

   assign bounds.width  = width_ff;
   assign bounds.height = height_ff;

endmodule

@@ sv/ccpe_weights.sv @@
// ---------------------------------------------------------------------------
// ccpe_weights
// Four-stage pipeline forming the four basis weights from t.
// ---------------------------------------------------------------------------
`include "cubic_curve_point_eval_macros.svh"

module ccpe_weights (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ccpe_pkg::req_type    in_item,
   output ccpe_pkg::tag_type    tag_out,
   output ccpe_pkg::weight_type weight_out
);
   import ccpe_pkg::*;

   tag_type tag_in;
   tag_type tag_ff [W_STAGES];

   // stage 1: clamp t, form u = 1 - t
   logic [PARAM_T_W-1:0] s1_t_in, s1_u_in, s1_t_ff, s1_u_ff;
   // stage 2: squares and cross term
   logic [PARAM_T_W-1:0] s2_t_ff, s2_u_ff;
   logic [SQ_W-1:0]      s2_tt_in, s2_uu_in, s2_tu_in;
   logic [SQ_W-1:0]      s2_tt_ff, s2_uu_ff, s2_tu_ff;
   // stage 3: cubes
   logic [CUBE_W-1:0]    s3_ttt_in, s3_uuu_in, s3_ttu_in, s3_tuu_in;
   logic [CUBE_W-1:0]    s3_ttt_ff, s3_uuu_ff, s3_ttu_ff, s3_tuu_ff;
   logic [SQ_W-1:0]      s3_tt_ff;
   logic [PARAM_T_W-1:0] s3_t_ff;
   // stage 4: weights
   logic [WEIGHT_W-1:0]  ttt_w, tuu_w, ttu_w, tts_w, tss_w;
   weight_type           s4_w_in, s4_w_ff;
   logic [WSUM_W-1:0]    w_total;

   // incoming side data
   always_comb begin
      tag_in.valid     = in_valid;
      tag_in.basis     = in_item.basis;
      tag_in.ctrl_x[0] = in_item.ctrl0_x;
      tag_in.ctrl_x[1] = in_item.ctrl1_x;
      tag_in.ctrl_x[2] = in_item.ctrl2_x;
      tag_in.ctrl_x[3] = in_item.ctrl3_x;
      tag_in.ctrl_y[0] = in_item.ctrl0_y;
      tag_in.ctrl_y[1] = in_item.ctrl1_y;
      tag_in.ctrl_y[2] = in_item.ctrl2_y;
      tag_in.ctrl_y[3] = in_item.ctrl3_y;
      tag_in.color     = in_item.pixel_color;
   end

   // side data shift line, valid bits cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < W_STAGES; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < W_STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // t above one saturates to one
   always_comb begin
      s1_t_in = (in_item.param_t > T_ONE) ? T_ONE : in_item.param_t;
      s1_u_in = T_ONE - s1_t_in;
   end

   always_comb begin
      s2_tt_in = s1_t_ff * s1_t_ff;
      s2_uu_in = s1_u_ff * s1_u_ff;
      s2_tu_in = s1_t_ff * s1_u_ff;
   end

   always_comb begin
      s3_ttt_in = s2_tt_ff * s2_t_ff;
      s3_uuu_in = s2_uu_ff * s2_u_ff;
      s3_ttu_in = s2_tt_ff * s2_u_ff;
      s3_tuu_in = s2_tu_ff * s2_u_ff;
   end

   // weights; wraparound in the middle terms cancels, final values fit
   always_comb begin
      ttt_w = WEIGHT_W'(s3_ttt_ff);
      tuu_w = WEIGHT_W'(s3_tuu_ff);
      ttu_w = WEIGHT_W'(s3_ttu_ff);
      tts_w = WEIGHT_W'(s3_tt_ff) << T_FRAC_BITS;
      tss_w = WEIGHT_W'(s3_t_ff) << (2 * T_FRAC_BITS);
      s4_w_in[0] = WEIGHT_W'(s3_uuu_ff);
      s4_w_in[3] = ttt_w;
      if (tag_ff[2].basis == BASIS_BSPLINE) begin
         s4_w_in[1] = ttt_w + (ttt_w << 1) + (S_CUBE << 2)
                      - (tts_w << 2) - (tts_w << 1);
         s4_w_in[2] = tts_w + (tts_w << 1) + tss_w + (tss_w << 1) + S_CUBE
                      - ttt_w - (ttt_w << 1);
      end else begin
         s4_w_in[1] = tuu_w + (tuu_w << 1);
         s4_w_in[2] = ttu_w + (ttu_w << 1);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_t_ff   <= s1_t_in;
      s1_u_ff   <= s1_u_in;
      s2_t_ff   <= s1_t_ff;
      s2_u_ff   <= s1_u_ff;
      s2_tt_ff  <= s2_tt_in;
      s2_uu_ff  <= s2_uu_in;
      s2_tu_ff  <= s2_tu_in;
      s3_ttt_ff <= s3_ttt_in;
      s3_uuu_ff <= s3_uuu_in;
      s3_ttu_ff <= s3_ttu_in;
      s3_tuu_ff <= s3_tuu_in;
      s3_tt_ff  <= s2_tt_ff;
      s3_t_ff   <= s2_t_ff;
      s4_w_ff   <= s4_w_in;
   end

   assign tag_out    = tag_ff[W_STAGES-1];
   assign weight_out = s4_w_ff;

   assign w_total = WSUM_W'(s4_w_ff[0]) + WSUM_W'(s4_w_ff[1])
                  + WSUM_W'(s4_w_ff[2]) + WSUM_W'(s4_w_ff[3]);

   `CCPE_ASSERT_IMPLY(a_t_clamped, tag_ff[0].valid, (s1_t_ff <= T_ONE) && (s1_t_ff + s1_u_ff == T_ONE))
   `CCPE_ASSERT_IMPLY(a_bezier_total, tag_out.valid && tag_out.basis == BASIS_BEZIER, w_total == BEZIER_SUM)
   `CCPE_ASSERT_IMPLY(a_bspline_total, tag_out.valid && tag_out.basis == BASIS_BSPLINE, w_total == BSPLINE_SUM)

endmodule

@@ sv/ccpe_combine.sv @@
// ---------------------------------------------------------------------------
// ccpe_combine
// Three-stage weighted sum of the control points, floored by S^3.
// ---------------------------------------------------------------------------
module ccpe_combine (
   input  logic                 clock,
   input  logic                 reset,
   input  ccpe_pkg::tag_type    tag_in,
   input  ccpe_pkg::weight_type weight_in,
   output ccpe_pkg::pos_type    pos_out
);
   import ccpe_pkg::*;

   tag_type tag_ff [C_STAGES-1];

   // stage 5: half-weight products, 16 small multipliers
   logic signed [PROD_W-1:0] plo_x_in [4], phi_x_in [4], plo_y_in [4], phi_y_in [4];
   logic signed [PROD_W-1:0] plo_x_ff [4], phi_x_ff [4], plo_y_ff [4], phi_y_ff [4];
   // stage 6: four-way sums of each half
   logic signed [SUM_W-1:0]  slo_x_in, shi_x_in, slo_y_in, shi_y_in;
   logic signed [SUM_W-1:0]  slo_x_ff, shi_x_ff, slo_y_ff, shi_y_ff;
   // stage 7: merge halves and floor
   logic signed [SUM_W-1:0]  m_x, m_y;
   pos_type                  pos_in, pos_ff;

   // side data tracks the product and sum stages; pos_ff is the last stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < C_STAGES-1; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < C_STAGES-1; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // weight = hi * 2^LO_W + lo; each half times each coordinate
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         plo_x_in[i] = $signed({1'b0, weight_in[i][LO_W-1:0]}) * $signed(tag_in.ctrl_x[i]);
         phi_x_in[i] = $signed({1'b0, weight_in[i][WEIGHT_W-1:LO_W]})
                       * $signed(tag_in.ctrl_x[i]);
         plo_y_in[i] = $signed({1'b0, weight_in[i][LO_W-1:0]}) * $signed(tag_in.ctrl_y[i]);
         phi_y_in[i] = $signed({1'b0, weight_in[i][WEIGHT_W-1:LO_W]})
                       * $signed(tag_in.ctrl_y[i]);
      end
   end

   always_comb begin
      slo_x_in = plo_x_ff[0] + plo_x_ff[1] + plo_x_ff[2] + plo_x_ff[3];
      shi_x_in = phi_x_ff[0] + phi_x_ff[1] + phi_x_ff[2] + phi_x_ff[3];
      slo_y_in = plo_y_ff[0] + plo_y_ff[1] + plo_y_ff[2] + plo_y_ff[3];
      shi_y_in = phi_y_ff[0] + phi_y_ff[1] + phi_y_ff[2] + phi_y_ff[3];
   end

   // nested floors: floor(acc / S^3) = floor((hi + floor(lo / 2^LO_W)) / 2^shift)
   always_comb begin
      m_x          = shi_x_ff + (slo_x_ff >>> LO_W);
      m_y          = shi_y_ff + (slo_y_ff >>> LO_W);
      pos_in.valid = tag_ff[C_STAGES-2].valid;
      pos_in.basis = tag_ff[C_STAGES-2].basis;
      pos_in.color = tag_ff[C_STAGES-2].color;
      pos_in.x     = m_x[FLOOR_SHIFT +: PX_W];
      pos_in.y     = m_y[FLOOR_SHIFT +: PX_W];
   end

   always_ff @(posedge clock) begin
      plo_x_ff <= plo_x_in;
      phi_x_ff <= phi_x_in;
      plo_y_ff <= plo_y_in;
      phi_y_ff <= phi_y_in;
      slo_x_ff <= slo_x_in;
      shi_x_ff <= shi_x_in;
      slo_y_ff <= slo_y_in;
      shi_y_ff <= shi_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.valid <= 1'b0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign pos_out = pos_ff;

endmodule

@@ sv/ccpe_finish.sv @@
// ---------------------------------------------------------------------------
// ccpe_finish
// Floor divide by six for B-spline points, bounds test, result register.
// ---------------------------------------------------------------------------
module ccpe_finish (
   input  logic                 clock,
   input  logic                 reset,
   input  ccpe_pkg::pos_type    pos_in,
   input  ccpe_pkg::bounds_type bounds,
   output logic                 rsp_strobe,
   output ccpe_pkg::rsp_type    rsp_data
);
   import ccpe_pkg::*;

   // stage 8: biased value times reciprocal of six
   logic [DIV_N_W-1:0]  n_x, n_y;
   logic [DIV_P_W-1:0]  s8_dx_in, s8_dy_in, s8_dx_ff, s8_dy_ff;
   logic                s8_valid_ff, s8_basis_ff;
   logic [COLOR_W-1:0]  s8_color_ff;
   coord_type           s8_px_ff, s8_py_ff;
   // stage 9: select, bounds, result
   logic [COORD_BITS:0] q_x, q_y;
   coord_type           fx, fy;
   rsp_type             rsp_in, rsp_ff;
   logic                strobe_ff;

   // n = px + 6 * 2^(COORD_BITS-1) is never negative
   always_comb begin
      n_x      = DIV_N_W'(pos_in.x) + DIV6_OFFSET;
      n_y      = DIV_N_W'(pos_in.y) + DIV6_OFFSET;
      s8_dx_in = n_x * DIV6_RECIP;
      s8_dy_in = n_y * DIV6_RECIP;
   end

   always_ff @(posedge clock) begin
      s8_dx_ff    <= s8_dx_in;
      s8_dy_ff    <= s8_dy_in;
      s8_basis_ff <= pos_in.basis;
      s8_color_ff <= pos_in.color;
      s8_px_ff    <= pos_in.x[COORD_BITS-1:0];
      s8_py_ff    <= pos_in.y[COORD_BITS-1:0];
   end

   // remove the bias, pick the basis result, test the image bounds
   always_comb begin
      q_x = s8_dx_ff[DIV_K +: COORD_BITS+1] - HALF_RANGE;
      q_y = s8_dy_ff[DIV_K +: COORD_BITS+1] - HALF_RANGE;
      fx  = (s8_basis_ff == BASIS_BSPLINE) ? q_x[COORD_BITS-1:0] : s8_px_ff;
      fy  = (s8_basis_ff == BASIS_BSPLINE) ? q_y[COORD_BITS-1:0] : s8_py_ff;
      rsp_in.point_x     = fx;
      rsp_in.point_y     = fy;
      rsp_in.inside_res  = !fx[COORD_BITS-1] && !fy[COORD_BITS-1]
                           && (CMP_W'($unsigned(fx)) < CMP_W'(bounds.width))
                           && (CMP_W'($unsigned(fy)) < CMP_W'(bounds.height));
      rsp_in.paint_color = s8_color_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         s8_valid_ff <= pos_in.valid;
         strobe_ff   <= s8_valid_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sv/cubic_curve_point_eval.sv @@
// ---------------------------------------------------------------------------
// cubic_curve_point_eval
// One cubic Bezier or uniform B-spline point per beat, floored to pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with req_data (basis, t, four control points,
//   color); the beat is taken at the clock edge where start is high and
//   busy is low. busy is high only while reset holds and until its register
//   clears after reset drops, so a new beat may enter on every cycle.
//   Result beat: rsp_strobe is high for exactly one cycle with rsp_data
//   (point, inside flag, color). The receiver cannot hold it off.
//   Register stages from the accept edge to the edge that takes the result:
//   4 for the weights, 3 for the weighted sum, 2 for the divide by six and
//   bounds test. Throughput: one beat per cycle.
//   Results leave in the order beats came in.
//   Config: APB writes image_width (address 0), image_height (address 4),
//   13 bits each; the user does them with no beats in flight, unenforced.
//   Reset: clears all valid bits in flight; width 640, height 480.
// ---------------------------------------------------------------------------
`include "cubic_curve_point_eval_macros.svh"

module cubic_curve_point_eval (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ccpe_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output ccpe_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ccpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ccpe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ccpe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ccpe_pkg::*;

   logic       busy_ff;
   logic       accept;
   tag_type    w_tag;
   weight_type w_weights;
   pos_type    c_pos;
   bounds_type bounds;

   // held off only around reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   ccpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .bounds  (bounds)
   );

   ccpe_weights u_weights (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_item    (req_data),
      .tag_out    (w_tag),
      .weight_out (w_weights)
   );

   ccpe_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (w_tag),
      .weight_in (w_weights),
      .pos_out   (c_pos)
   );

   ccpe_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .pos_in     (c_pos),
      .bounds     (bounds),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `CCPE_ASSERT_IMPLY(a_result_latency, rsp_strobe, $past(start && !busy, PIPE_DEPTH))
   `CCPE_ASSERT_IMPLY(a_inside_nonneg, rsp_strobe && rsp_data.inside_res, !rsp_data.point_x[COORD_BITS-1] && !rsp_data.point_y[COORD_BITS-1])
   `CCPE_ASSERT_NEXT(a_busy_released, 1'b1, !busy)

endmodule
